>>> rtl/hall_index_offset_calibrator_unit_macros.svh
// Assertion macros shared by the hall index offset calibrator RTL.
`ifndef HALL_INDEX_OFFSET_CALIBRATOR_UNIT_MACROS_SVH
`define HALL_INDEX_OFFSET_CALIBRATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every rising edge outside reset.
`define HIOC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hioc assertion failed");
// Condition must never be true at a rising edge outside reset.
`define HIOC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("hioc forbidden condition seen");
`else
`define HIOC_ASSERT(lbl, clk, rstn, prop)
`define HIOC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/hioc_pkg.sv
// Types, constants and saturation helper for the hall index offset calibrator.
package hioc_pkg;

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] raw_position;
    logic               hall_active;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] corrected_position;
    logic signed [31:0] current_offset;
    logic               is_calibrated;
  } out_item_t;

  // Carried from the tracking stage to the output stage.
  typedef struct packed {
    logic signed [31:0] raw_position;
    logic signed [31:0] offset;
    logic               calibrated;
  } mid_item_t;

  // Clamp a 33-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? QMin : QMax;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/hioc_track.sv
// Window and range tracking, calibration latch and offset computation.
`include "hall_index_offset_calibrator_unit_macros.svh"

module hioc_track (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  hioc_pkg::in_item_t        item_i,
  input  logic signed [31:0]        ref_pos_i,
  output hioc_pkg::mid_item_t       mid_o
);

  logic signed [31:0] win_max_q, win_max_d;
  logic signed [31:0] win_min_q, win_min_d;
  logic signed [31:0] ov_max_q, ov_max_d;
  logic signed [31:0] ov_min_q, ov_min_d;
  logic               first_q;
  logic               seen_q, seen_d;
  logic               cal_q, cal_d;
  logic signed [31:0] off_q, off_d;
  logic signed [32:0] win_sum;
  logic signed [31:0] centre;
  logic signed [32:0] diff;
  logic signed [31:0] pos;
  logic               hall;
  logic               bracketed;
  hioc_pkg::mid_item_t mid_q;

  assign pos  = item_i.raw_position;
  assign hall = item_i.hall_active;

  always_comb begin
    win_max_d = (hall && (!seen_q || pos > win_max_q)) ? pos : win_max_q;
    win_min_d = (hall && (!seen_q || pos < win_min_q)) ? pos : win_min_q;
    seen_d    = seen_q | hall;
    ov_max_d  = (first_q || pos > ov_max_q) ? pos : ov_max_q;
    ov_min_d  = (first_q || pos < ov_min_q) ? pos : ov_min_q;

    bracketed = seen_d && (ov_max_d > win_max_d) && (ov_min_d < win_min_d);
    cal_d     = bracketed || cal_q;

    // Midpoint rounds toward minus infinity; it always fits in 32 bits.
    win_sum = $signed({win_max_d[31], win_max_d}) + $signed({win_min_d[31], win_min_d});
    centre  = win_sum[32:1];
    diff    = $signed({ref_pos_i[31], ref_pos_i})
            - $signed({centre[31], centre});
    off_d   = cal_d ? hioc_pkg::sat33(diff) : off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_max_q <= '0;
      win_min_q <= '0;
      ov_max_q  <= '0;
      ov_min_q  <= '0;
      first_q   <= 1'b1;
      seen_q    <= 1'b0;
      cal_q     <= 1'b0;
      off_q     <= '0;
    end else if (adv_i) begin
      win_max_q <= win_max_d;
      win_min_q <= win_min_d;
      ov_max_q  <= ov_max_d;
      ov_min_q  <= ov_min_d;
      first_q   <= 1'b0;
      seen_q    <= seen_d;
      cal_q     <= cal_d;
      off_q     <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mid_q.raw_position <= pos;
      mid_q.offset       <= off_d;
      mid_q.calibrated   <= cal_d;
    end
  end

  assign mid_o = mid_q;

  `HIOC_ASSERT(a_cal_latched, clk_i, rst_ni, cal_q |=> cal_q)
  `HIOC_ASSERT(a_window_order, clk_i, rst_ni, seen_q |-> (win_min_q <= win_max_q))
  `HIOC_ASSERT(a_window_in_range, clk_i, rst_ni,
    seen_q |-> ((ov_min_q <= win_min_q) && (win_max_q <= ov_max_q)))

endmodule

>>> rtl/hioc_out.sv
// Output register: corrected position with saturation.
module hioc_out (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  hioc_pkg::mid_item_t  mid_i,
  output hioc_pkg::out_item_t  out_o
);

  logic signed [32:0]  sum;
  hioc_pkg::out_item_t out_q;

  assign sum = $signed({mid_i.raw_position[31], mid_i.raw_position})
             + $signed({mid_i.offset[31], mid_i.offset});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q.corrected_position <= hioc_pkg::sat33(sum);
      out_q.current_offset     <= mid_i.offset;
      out_q.is_calibrated      <= mid_i.calibrated;
    end
  end

  assign out_o = out_q;

endmodule

>>> rtl/hall_index_offset_calibrator_unit.sv
// Top level of the hall index offset calibrator.
// The block takes one position sample with its hall bit per transfer and returns one
// result per transfer: the position corrected by the learned offset, the offset itself
// and the calibrated flag. It accepts a new transfer in every clock cycle unless a
// stalled output has filled the pipeline. The three registers in the path are the
// input register, the tracking stage (which holds the window and range extremes and
// the offset, updated as each sample leaves the input register) and the output
// register, where the corrected position is saturated. The sustained rate of one
// transfer per cycle while the output is not stalled is set by the loop through the
// tracking state: compares, one add of the window extremes, a halving shift and one
// subtract from the magnet reference position. That reference is written through
// cfg_we_i and cfg_wdata_i and must only change while no transfer is in flight.
`include "hall_index_offset_calibrator_unit_macros.svh"

module hall_index_offset_calibrator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic signed [31:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hioc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hioc_pkg::out_item_t  out_data_o
);

  logic signed [31:0]  magnet_q;
  logic                in_valid_q;
  hioc_pkg::in_item_t  in_data_q;
  logic                mid_valid_q;
  logic                out_valid_q;
  hioc_pkg::mid_item_t mid;
  logic                ready_out;
  logic                ready_mid;
  logic                ready_in;
  logic                adv_mid;
  logic                load_out;

  // Each stage can take a new entry when it is empty or when its own entry moves on.
  assign ready_out = !out_valid_q || !out_stall_i;
  assign ready_mid = !mid_valid_q || ready_out;
  assign ready_in  = !in_valid_q || ready_mid;
  assign adv_mid   = in_valid_q && ready_mid;
  assign load_out  = mid_valid_q && ready_out;

  assign in_stall_o  = !ready_in;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnet_q    <= '0;
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        magnet_q <= cfg_wdata_i;
      end
      if (ready_in) begin
        in_valid_q <= in_valid_i;
      end
      if (ready_mid) begin
        mid_valid_q <= in_valid_q;
      end
      if (ready_out) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_in) begin
      in_data_q <= in_data_i;
    end
  end

  hioc_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv_mid),
    .item_i    (in_data_q),
    .ref_pos_i (magnet_q),
    .mid_o     (mid)
  );

  hioc_out u_out (
    .clk_i  (clk_i),
    .load_i (load_out),
    .mid_i  (mid),
    .out_o  (out_data_o)
  );

  `HIOC_ASSERT_NEVER(a_stall_when_empty, clk_i, rst_ni, !out_valid_q && in_stall_o)
  `HIOC_ASSERT(a_mid_fills, clk_i, rst_ni, (in_valid_q && !mid_valid_q) |=> mid_valid_q)
  `HIOC_ASSERT(a_out_held, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> out_valid_q)

endmodule

>>> tb/tb_hall_index_offset_calibrator_unit.sv
// Self-checking testbench for the hall index offset calibrator unit.
module tb_hall_index_offset_calibrator_unit;

  // Run length: the directed table, then seven random phases with a new
  // magnet position written before each one.
  localparam int RandPhases   = 7;
  localparam int PhaseSamples = 250;
  localparam int RandSamples  = RandPhases * PhaseSamples;
  // Worst case is roughly 1800 transfers, each meeting the longest sender gap
  // and the longest output stall; the limit sits well above that.
  localparam int CycleLimit   = 1000000;
  // Cycles waited once no result is pending, so a stray extra result is caught.
  localparam int DrainCycles  = 8;

  typedef enum bit {
    ROW_SAMPLE,
    ROW_MAGNET
  } row_kind_e;

  // One line of the directed table. A ROW_MAGNET line writes the magnet
  // position; a ROW_SAMPLE line sends one sample. Where typed is set, the
  // expected result is the one written in the table.
  typedef struct packed {
    row_kind_e           kind;
    logic signed [31:0]  value;
    logic                hall;
    logic                typed;
    hioc_pkg::out_item_t want;
  } dir_row_t;

  localparam int DirRows = 24;

  // The walk starts with a sample that is both the first sample and the
  // first hall sample, so the window and the overall range are equal and
  // nothing is calibrated. The range then grows one side at a time, and
  // calibration latches only once both sides are outside the window. The
  // magnet is then pushed to each extreme to force the offset and the
  // corrected position into saturation in both directions. A hall sample
  // that makes the window sum odd and negative checks that the halving
  // rounds toward minus infinity. Windows stay narrow so that the random
  // part still has room to widen them.
  dir_row_t dir_rows [DirRows] = '{
    '{ROW_MAGNET, 32'sh0000_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0001_0000, 1'b1, 1'b1, '{32'sh0001_0000, 32'sh0000_0000, 1'b0}},
    '{ROW_SAMPLE, 32'sh7FFF_FFFF, 1'b0, 1'b1, '{32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0}},
    '{ROW_SAMPLE, 32'sh8000_0000, 1'b0, 1'b1, '{32'sh8000_0000, 32'shFFFF_0000, 1'b1}},
    '{ROW_MAGNET, 32'sh8000_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0004_0000, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh8000_0000, 1'b0, 1'b1, '{32'sh8000_0000, 32'sh8000_0000, 1'b1}},
    '{ROW_SAMPLE, 32'sh7FFF_FFFF, 1'b0, 1'b1, '{32'shFFFF_FFFF, 32'sh8000_0000, 1'b1}},
    '{ROW_MAGNET, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'shFFF8_0000, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh7FFF_FFFF, 1'b0, 1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1}},
    '{ROW_SAMPLE, 32'sh8000_0000, 1'b0, 1'b1, '{32'shFFFF_FFFF, 32'sh7FFF_FFFF, 1'b1}},
    '{ROW_MAGNET, 32'sh0001_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'shFFF7_FFFF, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0000_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh5555_AAAA, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'shAAAA_5555, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0000_1234, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 32'shFFFF_FFFF, 1'b1, 1'b0, '0},
    '{ROW_MAGNET, 32'sh0000_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0001_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh7FFF_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh8001_0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 32'sh0000_0001, 1'b1, 1'b0, '0}
  };

  // Block inputs start at known values before the first clock edge.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic signed [31:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hioc_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hioc_pkg::out_item_t out_data_o;

  // Calibrator state as the testbench expects it to be.
  logic signed [31:0] magnet_pos  = '0;
  logic signed [31:0] win_hi      = '0;
  logic signed [31:0] win_lo      = '0;
  logic signed [31:0] span_hi     = '0;
  logic signed [31:0] span_lo     = '0;
  logic signed [31:0] offset_q    = '0;
  bit                 fresh_start = 1'b1;
  bit                 magnet_hit  = 1'b0;
  bit                 locked      = 1'b0;

  // Results owed by the block, oldest first.
  hioc_pkg::out_item_t pending_results [$];

  int fails         = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int magnet_writes = 0;
  int cycles        = 0;
  bit lock_seen     = 1'b0;

  hall_index_offset_calibrator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held at the start and never again.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("run did not finish within %0d cycles, %0d results outstanding",
             CycleLimit, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_q(longint v);
    if (v > longint'(hioc_pkg::QMax)) begin
      return hioc_pkg::QMax;
    end
    if (v < longint'(hioc_pkg::QMin)) begin
      return hioc_pkg::QMin;
    end
    return v[31:0];
  endfunction

  // Advance the expected state by one sample and return its result. The
  // window follows hall samples only, the overall range follows every
  // sample, and once the window sits strictly inside the range (or the
  // block is already calibrated) the offset is recomputed from the window
  // center. The center is the floor of half the window sum.
  function automatic hioc_pkg::out_item_t track_sample(hioc_pkg::in_item_t s);
    hioc_pkg::out_item_t r;
    longint              centre;
    if (s.hall_active) begin
      if (s.raw_position > win_hi || !magnet_hit) begin
        win_hi = s.raw_position;
      end
      if (s.raw_position < win_lo || !magnet_hit) begin
        win_lo = s.raw_position;
      end
      magnet_hit = 1'b1;
    end
    if (s.raw_position > span_hi || fresh_start) begin
      span_hi = s.raw_position;
    end
    if (s.raw_position < span_lo || fresh_start) begin
      span_lo = s.raw_position;
    end
    if ((magnet_hit && span_hi > win_hi && span_lo < win_lo) || locked) begin
      centre   = (longint'(win_hi) + longint'(win_lo)) >>> 1;
      offset_q = clamp_q(longint'(magnet_pos) - centre);
      locked   = 1'b1;
    end
    fresh_start = 1'b0;
    r.corrected_position = clamp_q(longint'(s.raw_position) + longint'(offset_q));
    r.current_offset     = offset_q;
    r.is_calibrated      = locked;
    return r;
  endfunction

  // Idle length for either side: mostly none, often a few cycles, and now
  // and then a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offer one sample and hold it until the block takes it. The expectation
  // is recorded at the edge of the transfer, so the state always follows
  // the block's order of acceptance.
  task automatic send_sample(hioc_pkg::in_item_t s, bit typed, hioc_pkg::out_item_t want);
    hioc_pkg::out_item_t calc;
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    calc = track_sample(s);
    pending_results.push_back(typed ? want : calc);
    samples_sent++;
  endtask

  task automatic idle_sender(int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The magnet position may change only with nothing in flight. Every
  // sample yields a result, so an empty queue means the block is idle.
  // This is also where the sender holds off until all results are in.
  task automatic load_magnet(logic signed [31:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    magnet_pos = v;
    magnet_writes++;
  endtask

  // Output side: runs of ready cycles broken by stalls of random length,
  // with an occasional long run of no stalls at all.
  initial begin
    int run;
    int hold;
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(1, 20);
      hold = pick_gap();
      repeat (run) @(posedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each result transfer is checked field by field against the oldest
  // expectation.
  always @(posedge clk_i) begin
    hioc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing pending: %h", out_data_o);
        fails++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_data_o.is_calibrated) begin
          lock_seen = 1'b1;
        end
        if (out_data_o.corrected_position !== want.corrected_position) begin
          $error("corrected_position: expected %h, got %h",
                 want.corrected_position, out_data_o.corrected_position);
          fails++;
        end
        if (out_data_o.current_offset !== want.current_offset) begin
          $error("current_offset: expected %h, got %h",
                 want.current_offset, out_data_o.current_offset);
          fails++;
        end
        if (out_data_o.is_calibrated !== want.is_calibrated) begin
          $error("is_calibrated: expected %b, got %b",
                 want.is_calibrated, out_data_o.is_calibrated);
          fails++;
        end
      end
    end
  end

  // Stimulus: the directed table first, then the random phases.
  initial begin
    hioc_pkg::in_item_t s;
    logic signed [31:0] draw;
    logic signed [31:0] next_magnet;
    int                 idx;
    int                 lo_shift;
    bit                 no_gaps;
    while (!rst_ni) begin
      @(posedge clk_i);
    end

    for (int k = 0; k < DirRows; k++) begin
      if (dir_rows[k].kind == ROW_MAGNET) begin
        load_magnet(dir_rows[k].value);
      end else begin
        s.raw_position = dir_rows[k].value;
        s.hall_active  = dir_rows[k].hall;
        send_sample(s, dir_rows[k].typed, dir_rows[k].want);
        idle_sender(pick_gap());
      end
    end

    // Random phases. The first three use both extremes and zero for the
    // magnet position. Hall samples start close to zero and are allowed
    // to grow toward full scale over the run, so the window keeps widening
    // and the offset keeps moving instead of settling early.
    idx = 0;
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          next_magnet = hioc_pkg::QMax;
        end
        1: begin
          next_magnet = hioc_pkg::QMin;
        end
        2: begin
          next_magnet = '0;
        end
        default: begin
          draw = $urandom;
          next_magnet = (p % 2 == 1) ? draw : (draw >>> 12);
        end
      endcase
      load_magnet(next_magnet);
      // Every third phase runs back to back with no sender gaps.
      no_gaps = (p % 3 == 2);
      for (int j = 0; j < PhaseSamples; j++) begin
        lo_shift = 31 - (31 * idx) / RandSamples;
        draw     = $urandom;
        s.hall_active = ($urandom_range(0, 2) == 0);
        if (s.hall_active) begin
          s.raw_position = draw >>> $urandom_range(31, lo_shift);
        end else if ($urandom_range(0, 1) == 0) begin
          s.raw_position = draw;
        end else begin
          s.raw_position = draw >>> $urandom_range(31, 0);
        end
        send_sample(s, 1'b0, '0);
        if (!no_gaps) begin
          idle_sender(pick_gap());
        end
        idx++;
      end
    end

    // Let the pipeline drain, then give it a few more cycles so that any
    // extra result would still be caught by the checker.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d samples across %0d magnet positions; %0d results checked.",
             samples_sent, magnet_writes, results_seen);
    $display("Calibration observed: %s; mismatches: %0d.",
             lock_seen ? "yes" : "no", fails);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
